@@ src/pmvd_pkg.sv @@
`default_nettype none
package pmvd_pkg;

	localparam int LANES       = 4;
	localparam int LANE_W      = 16;
	localparam int FRAC_BITS   = LANE_W / 2;
	localparam int PROD_W      = 2 * LANE_W;
	localparam int ACC_W       = 40;
	localparam int PACKET_W    = LANES * LANE_W;
	localparam int STORE_DEPTH = 64;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int LEN_W       = 7;
	localparam int ROW_W       = 16;
	localparam int MAX_ROW_PACKETS = 64;
	localparam int PAIR_W      = ACC_W + 1;
	localparam int TOTAL_W     = ACC_W + 2;
	localparam int SUM_W       = 16;

	localparam logic REG_ROW_PACKETS = 1'b0;
	localparam logic REG_ROW_COUNT   = 1'b1;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_STREAM = 1'b1;

	typedef struct packed {
		logic             close;
		logic [ROW_W-1:0] row_index;
		logic             last;
	} pmvd_tag_t;

endpackage
`default_nettype wire

@@ src/pmvd_vec_mem.sv @@
`default_nettype none
module pmvd_vec_mem (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [pmvd_pkg::SLOT_W-1:0]   wr_addr,
	input  wire logic [pmvd_pkg::PACKET_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [pmvd_pkg::SLOT_W-1:0]   rd_addr,
	output logic      [pmvd_pkg::PACKET_W-1:0] rd_data
);
	import pmvd_pkg::*;

	logic [PACKET_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ src/pmvd_mac.sv @@
`default_nettype none
module pmvd_mac (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic                        valid_s1,
	input  wire pmvd_pkg::pmvd_tag_t         tag_s1,
	input  wire logic [pmvd_pkg::PACKET_W-1:0] packet_s1,
	input  wire logic [pmvd_pkg::PACKET_W-1:0] vec_s1,
	output logic                             valid_s3,
	output pmvd_pkg::pmvd_tag_t              tag_s3,
	output logic [pmvd_pkg::LANES-1:0][pmvd_pkg::ACC_W-1:0] fin_s3
);
	import pmvd_pkg::*;

	logic                          valid_s2;
	pmvd_tag_t                     tag_s2;
	logic [LANES-1:0][PROD_W-1:0]  prod_s2;
	logic [LANES-1:0][ACC_W-1:0]   sums_q;
	logic [LANES-1:0][ACC_W-1:0]   sums_next;
	logic [LANES-1:0][PROD_W-1:0]  prod_next;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod_next[l] = PROD_W'($signed(packet_s1[l*LANE_W +: LANE_W]))
				* PROD_W'($signed(vec_s1[l*LANE_W +: LANE_W]));
			sums_next[l] = sums_q[l]
				+ {{(ACC_W-PROD_W){prod_s2[l][PROD_W-1]}}, prod_s2[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			sums_q   <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && tag_s2.close;
			if (valid_s2) begin
				sums_q <= tag_s2.close ? '0 : sums_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= prod_next;
			tag_s2  <= tag_s1;
			fin_s3  <= sums_next;
			tag_s3  <= tag_s2;
		end
	end

endmodule
`default_nettype wire

@@ src/pmvd_reduce.sv @@
`default_nettype none
module pmvd_reduce (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire logic                      valid_s3,
	input  wire pmvd_pkg::pmvd_tag_t       tag_s3,
	input  wire logic [pmvd_pkg::LANES-1:0][pmvd_pkg::ACC_W-1:0] fin_s3,
	output logic                           valid_s4,
	output pmvd_pkg::pmvd_tag_t            tag_s4,
	output logic signed [pmvd_pkg::SUM_W-1:0] sum_s4,
	output logic                           sat_s4
);
	import pmvd_pkg::*;

	logic [LANES/2-1:0][PAIR_W-1:0] pair_s4;
	logic signed [TOTAL_W-1:0]           total;
	logic signed [TOTAL_W-FRAC_BITS-1:0] shifted;

	always_comb begin
		total = '0;
		for (int j = 0; j < LANES/2; j++) begin
			total = total + TOTAL_W'($signed(pair_s4[j]));
		end
		shifted = (TOTAL_W-FRAC_BITS)'(total >>> FRAC_BITS);
		if (shifted > $signed((TOTAL_W-FRAC_BITS)'(32767))) begin
			sum_s4 = 16'sh7fff;
			sat_s4 = 1'b1;
		end else if (shifted < -$signed((TOTAL_W-FRAC_BITS)'(32768))) begin
			sum_s4 = 16'sh8000;
			sat_s4 = 1'b1;
		end else begin
			sum_s4 = SUM_W'(shifted);
			sat_s4 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s4 <= tag_s3;
			for (int j = 0; j < LANES/2; j++) begin
				pair_s4[j] <= PAIR_W'($signed(fin_s3[2*j]))
					+ PAIR_W'($signed(fin_s3[2*j+1]));
			end
		end
	end

endmodule
`default_nettype wire

@@ src/packed_matrix_vector_dot.sv @@
// A row result appears on m_tvalid from the output register after its last packet leaves s4.
// Throughput: one word per cycle unless held; each lane sum is a one-register accumulate loop.
// The pipeline holds only when a result reaches the last stage while the output word waits.
// Asynchronous active-low reset clears positions and lane sums and sets both registers to 1.
// The vector store is not cleared and holds unknown data until loaded.
`default_nettype none
module packed_matrix_vector_dot (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // packet[63:0], vector_slot[69:64], zero pad
	input  wire logic        s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // row_sum[15:0], row_index[31:16]
	output logic             m_tuser,  // saturated
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import pmvd_pkg::*;

	logic [LEN_W-1:0]    row_packets_q;
	logic [ROW_W-1:0]    row_count_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [ROW_W-1:0]    row_q;
	logic                advance;
	logic                accept;
	logic                stream;
	logic [LEN_W-1:0]    len;
	logic [ROW_W-1:0]    count;
	logic [SLOT_W-1:0]   pos_next;
	logic                last;
	pmvd_tag_t           tag_s0;
	logic                valid_s1;
	pmvd_tag_t           tag_s1;
	logic [PACKET_W-1:0] packet_s1;
	logic [PACKET_W-1:0] vec_s1;
	logic                valid_s3;
	pmvd_tag_t           tag_s3;
	logic [LANES-1:0][ACC_W-1:0] fin_s3;
	logic                valid_s4;
	pmvd_tag_t           tag_s4;
	logic signed [SUM_W-1:0] sum_s4;
	logic                sat_s4;
	logic                out_valid_q;
	logic [31:0]         out_data_q;
	logic                out_sat_q;
	logic                out_last_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ROW_COUNT) ? {16'b0, row_count_q}
		: {25'b0, row_packets_q};

	assign advance  = !(out_valid_q && !m_tready && valid_s4);
	assign s_tready = advance;
	assign accept   = s_tvalid && advance;
	assign stream   = accept && (s_tuser == FUNC_STREAM);

	always_comb begin
		if (row_packets_q == '0) begin
			len = LEN_W'(1);
		end else if (row_packets_q > LEN_W'(MAX_ROW_PACKETS)) begin
			len = LEN_W'(MAX_ROW_PACKETS);
		end else begin
			len = row_packets_q;
		end
		count    = (row_count_q == '0) ? ROW_W'(1) : row_count_q;
		pos_next = pos_q + SLOT_W'(1);
		last     = ({1'b0, row_q} + 17'd1) >= {1'b0, count};
		tag_s0.close     = (pos_next == '0) || ({1'b0, pos_next} >= len);
		tag_s0.row_index = row_q;
		tag_s0.last      = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_packets_q <= LEN_W'(1);
			row_count_q   <= ROW_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_ROW_COUNT) begin
				row_count_q <= pwdata[ROW_W-1:0];
			end else begin
				row_packets_q <= pwdata[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= stream;
			if (stream) begin
				if (tag_s0.close) begin
					pos_q <= '0;
					row_q <= last ? '0 : row_q + ROW_W'(1);
				end else begin
					pos_q <= pos_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s1    <= tag_s0;
			packet_s1 <= s_tdata[PACKET_W-1:0];
		end
	end

	pmvd_vec_mem u_mem (
		.clk     (clk),
		.wr_en   (accept && (s_tuser == FUNC_LOAD)),
		.wr_addr (s_tdata[PACKET_W +: SLOT_W]),
		.wr_data (s_tdata[PACKET_W-1:0]),
		.rd_en   (advance),
		.rd_addr (pos_q),
		.rd_data (vec_s1)
	);

	pmvd_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.tag_s1    (tag_s1),
		.packet_s1 (packet_s1),
		.vec_s1    (vec_s1),
		.valid_s3  (valid_s3),
		.tag_s3    (tag_s3),
		.fin_s3    (fin_s3)
	);

	pmvd_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s3 (valid_s3),
		.tag_s3   (tag_s3),
		.fin_s3   (fin_s3),
		.valid_s4 (valid_s4),
		.tag_s4   (tag_s4),
		.sum_s4   (sum_s4),
		.sat_s4   (sat_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && valid_s4) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s4) begin
			out_data_q <= {tag_s4.row_index, sum_s4};
			out_sat_q  <= sat_s4;
			out_last_q <= tag_s4.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

@@ tb/packed_matrix_vector_dot_tb.sv @@
module packed_matrix_vector_dot_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmvd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [2:0] ROW_PACKETS_ADDR = {REG_ROW_PACKETS, 2'b00};
	localparam logic [2:0] ROW_COUNT_ADDR = {REG_ROW_COUNT, 2'b00};

	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
		logic [63:0]       packet;
	} mv_word_t;

	typedef struct packed {
		logic [15:0] row_sum;
		logic [15:0] row_index;
		logic        sat;
		logic        last;
	} row_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;  // packet[63:0], vector_slot[69:64], zero pad
	logic        s_tuser = 1'b0;  // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // row_sum[15:0], row_index[31:16]
	logic        m_tuser;  // saturated
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	packed_matrix_vector_dot u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	mv_word_t    pending_words[$];
	row_result_t expected_rows[$];
	mv_word_t    current_word = '0;
	mv_word_t    next_word;
	logic        in_taken = 1'b0;
	int          in_gap = 0;
	int          out_hold = 0;
	logic        calm = 1'b0;
	logic        long_hold_req = 1'b0;
	logic        long_hold_done = 1'b0;
	int          cycle_count = 0;
	int          error_count = 0;
	int          words_queued = 0;
	int          loads_queued = 0;
	int          rows_seen = 0;
	int          sat_seen = 0;
	int          last_seen = 0;
	int          settings_used = 0;

	// Predictor state, mirroring the block's registers and accumulators.
	logic [63:0]             vec_store[STORE_DEPTH];
	logic signed [ACC_W-1:0] lane_acc[LANES];
	logic [SLOT_W-1:0]       pkt_pos = '0;
	logic [ROW_W-1:0]        row_pos = '0;
	logic [LEN_W-1:0]        cfg_len = 7'd1;
	logic [ROW_W-1:0]        cfg_rows = 16'd1;

	// Stimulus-side view of the packet position, so that no unloaded entry is read.
	logic [SLOT_W-1:0] gen_pos = '0;
	logic              slot_loaded[STORE_DEPTH];

	initial begin
		for (int i = 0; i < LANES; i++)
			lane_acc[i] = '0;
		for (int i = 0; i < STORE_DEPTH; i++)
			slot_loaded[i] = 1'b0;
	end

	function automatic int unsigned eff_row_len();
		if (cfg_len == 0)
			return 1;
		if (cfg_len > MAX_ROW_PACKETS)
			return MAX_ROW_PACKETS;
		return cfg_len;
	endfunction

	function automatic void absorb_word(mv_word_t w);
		logic [63:0]                vec;
		logic signed [TOTAL_W-1:0] total;
		int unsigned                count;
		row_result_t                r;
		if (w.func == FUNC_LOAD) begin
			vec_store[w.slot] = w.packet;
			return;
		end
		count = (cfg_rows == 0) ? 1 : cfg_rows;
		vec = vec_store[pkt_pos];
		for (int i = 0; i < LANES; i++)
			lane_acc[i] = lane_acc[i] + $signed(w.packet[i*LANE_W +: LANE_W])
				* $signed(vec[i*LANE_W +: LANE_W]);
		pkt_pos = pkt_pos + 1'b1;
		if (pkt_pos != 0 && pkt_pos < eff_row_len())
			return;
		total = (lane_acc[0] + lane_acc[1]) + (lane_acc[2] + lane_acc[3]);
		total = total >>> FRAC_BITS;
		r.sat = 1'b1;
		if (total > 32767)
			r.row_sum = 16'h7FFF;
		else if (total < -32768)
			r.row_sum = 16'h8000;
		else begin
			r.row_sum = total[15:0];
			r.sat = 1'b0;
		end
		r.row_index = row_pos;
		r.last = (32'(row_pos) + 1 >= count);
		expected_rows.push_back(r);
		row_pos = r.last ? '0 : row_pos + 1'b1;
		pkt_pos = '0;
		for (int i = 0; i < LANES; i++)
			lane_acc[i] = '0;
	endfunction

	function automatic logic [15:0] pick_lane();
		int v;
		v = $urandom_range(0, 1023) - 512;
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return v[15:0];
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] pick_packet();
		if ($urandom_range(0, 3) == 0)
			return {$urandom, $urandom};
		return {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
	endfunction

	task automatic queue_load(logic [SLOT_W-1:0] slot, logic [63:0] p);
		pending_words.push_back('{func: FUNC_LOAD, slot: slot, packet: p});
		slot_loaded[slot] = 1'b1;
		words_queued++;
		loads_queued++;
	endtask

	task automatic queue_row_packet(logic [63:0] p);
		if (!slot_loaded[gen_pos])
			queue_load(gen_pos, pick_packet());
		pending_words.push_back('{func: FUNC_STREAM, slot: SLOT_W'($urandom), packet: p});
		words_queued++;
		gen_pos = gen_pos + 1'b1;
		if (gen_pos != 0 && gen_pos >= eff_row_len())
			gen_pos = '0;
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ROW_PACKETS_ADDR)
			cfg_len = value[LEN_W-1:0];
		else
			cfg_rows = value[ROW_W-1:0];
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || s_tvalid || expected_rows.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(int len, int rows, int n);
		wait_idle();
		write_reg(ROW_PACKETS_ADDR, 32'(len));
		write_reg(ROW_COUNT_ADDR, 32'(rows));
		settings_used++;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15)
				queue_load(SLOT_W'($urandom), pick_packet());
			else
				queue_row_packet(pick_packet());
		end
	endtask

	// Sender: one word at a time, with random gaps between words.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			s_tvalid <= 1'b1;
		end else if (in_gap != 0) begin
			in_gap <= in_gap - 1;
			s_tvalid <= 1'b0;
		end else if (!calm && pending_words.size() != 0 && $urandom_range(0, 7) == 0) begin
			in_gap <= $urandom_range(0, 12);
			s_tvalid <= 1'b0;
		end else if (pending_words.size() != 0) begin
			next_word = pending_words.pop_front();
			current_word <= next_word;
			s_tdata <= {2'b00, next_word.slot, next_word.packet};
			s_tuser <= next_word.func;
			s_tvalid <= 1'b1;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done <= 1'b1;
			out_hold <= LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (out_hold != 0) begin
			out_hold <= out_hold - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_hold <= $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		row_result_t exp_row;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run timed out after %0d cycles.", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				absorb_word(current_word);
			if (m_tvalid && m_tready) begin
				rows_seen++;
				if (expected_rows.size() == 0) begin
					$error("unexpected row result: row_sum %0d row_index %0d",
						$signed(m_tdata[15:0]), m_tdata[31:16]);
					error_count++;
				end else begin
					exp_row = expected_rows.pop_front();
					sat_seen += exp_row.sat;
					last_seen += exp_row.last;
					if (m_tdata[15:0] !== exp_row.row_sum) begin
						$error("row_sum: expected %0d, got %0d",
							$signed(exp_row.row_sum), $signed(m_tdata[15:0]));
						error_count++;
					end
					if (m_tdata[31:16] !== exp_row.row_index) begin
						$error("row_index: expected %0d, got %0d",
							exp_row.row_index, m_tdata[31:16]);
						error_count++;
					end
					if (m_tuser !== exp_row.sat) begin
						$error("saturated: expected %0b, got %0b", exp_row.sat, m_tuser);
						error_count++;
					end
					if (m_tlast !== exp_row.last) begin
						$error("last_row: expected %0b, got %0b", exp_row.last, m_tlast);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset settings: one packet per row, one row.
		queue_load(6'd0, {4{16'h8000}});
		queue_row_packet({4{16'h8000}});
		queue_row_packet({4{16'h7FFF}});
		queue_row_packet(64'd0);
		queue_load(6'd0, 64'h0000_0000_0000_0001);
		queue_row_packet(64'h0000_0000_0000_FFFF);
		queue_row_packet(64'h0000_0000_0000_00FF);
		queue_load(6'd0, {4{16'h0100}});
		queue_row_packet({16'hFF00, 16'h0100, 16'h8000, 16'h7FFF});
		queue_row_packet({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
		queue_load(6'd63, {4{16'hFFFF}});
		queue_row_packet({4{16'hFFFF}});

		// Zero in both registers acts as one; large values clamp or run long rows.
		run_phase(0, 0, 20);
		run_phase(127, 65535, 200);
		run_phase(64, 3, 150);
		run_phase(1, 1, 120);
		long_hold_req = 1'b1;
		run_phase(2, 7, 200);
		// A longer row length and a shorter row count now take effect part way through a row.
		run_phase(3, 2, 150);
		run_phase(5, 65535, 150);
		wait_idle();
		calm = 1'b1;
		run_phase(7, 4, 180);
		wait_idle();

		$display("Covered %0d words (%0d vector loads) over %0d register settings.",
			words_queued, loads_queued, settings_used);
		$display("Checked %0d row results, %0d saturated and %0d marked as final row.",
			rows_seen, sat_seen, last_seen);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
